// ----- sv/stoub_pkg.sv -----
// stoub_pkg: shared widths, character codes, status codes, result type and
// the digit decoding function for the string-to-unsigned converter.
// No dependencies; compiled first.
package stoub_pkg;

  localparam int CH_W   = 8;
  localparam int VAL_W  = 64;
  localparam int POS_W  = 16;
  localparam int BASE_W = 6;
  localparam int DIG_W  = 6;
  localparam int STAT_W = 2;

  localparam logic [POS_W-1:0]  MAX_OFFSET = 16'hFFFF;
  localparam logic [BASE_W-1:0] TOP_BASE   = 6'd36;
  localparam logic [DIG_W-1:0]  DIGIT_NONE = 6'd63;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF      = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_BASE = 2'd2;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  end_offset;
    logic              converted;
    logic [STAT_W-1:0] status;
  } stoub_res_t;

  // digit value of a character, DIGIT_NONE when it is no digit in any base
  function automatic logic [DIG_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [DIG_W-1:0] d;
    d = DIGIT_NONE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIG_W'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIG_W'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIG_W'(c - CH_UA + 8'd10);
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- sv/stoub_in_if.sv -----
// stoub_in_if: character channel into the converter (valid/ready/ch).
// Depends on stoub_pkg.
interface stoub_in_if;
  logic                        valid;
  logic                        ready;
  logic [stoub_pkg::CH_W-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// ----- sv/stoub_out_if.sv -----
// stoub_out_if: result channel out of the converter.
// Depends on stoub_pkg.
interface stoub_out_if;
  logic                          valid;
  logic                          ready;
  logic [stoub_pkg::VAL_W-1:0]   value;
  logic [stoub_pkg::POS_W-1:0]   end_offset;
  logic                          converted;
  logic [stoub_pkg::STAT_W-1:0]  status;

  modport source (output valid, output value, output end_offset, output converted,
                  output status, input ready);
  modport sink   (input valid, input value, input end_offset, input converted,
                  input status, output ready);
endinterface

// ----- sv/stoub_core.sv -----
// stoub_core: per-string parse state and the one-character step logic
// (sign, prefix, multiply-accumulate with overflow check, result build).
// Depends on stoub_pkg.
module stoub_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic [stoub_pkg::CH_W-1:0]     ch,
  input  logic [stoub_pkg::BASE_W-1:0]   cfg_base,
  output logic                           emit,
  output stoub_pkg::stoub_res_t          res
);

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_ZEROX  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_WAIT   = 3'd5;

  localparam int PROD_W = stoub_pkg::VAL_W + stoub_pkg::BASE_W;

  logic [2:0]                      phase_r, phase_nxt;
  logic [stoub_pkg::VAL_W-1:0]     acc_r, acc_nxt;
  logic                            minus_r, minus_nxt;
  logic [stoub_pkg::BASE_W-1:0]    wbase_r, wbase_nxt;
  logic [stoub_pkg::POS_W-1:0]     char_pos_r, char_pos_nxt;
  logic [stoub_pkg::POS_W-1:0]     sign_pos_r, sign_pos_nxt;
  logic [stoub_pkg::POS_W-1:0]     stop_pos_r, stop_pos_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            digits_r, digits_nxt;
  logic                            bad_r, bad_nxt;

  logic [stoub_pkg::BASE_W-1:0]    sig_base;
  logic [stoub_pkg::BASE_W-1:0]    dbase_raw;
  logic [stoub_pkg::BASE_W-1:0]    dbase;
  logic [stoub_pkg::DIG_W-1:0]     dig;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W:0]                 sum;
  logic                            ovf_hit;
  logic                            is_nul;
  logic                            is_x;
  logic                            is_oct;
  logic                            cfg_bad;
  logic                            do_signed;
  logic                            do_digit;

  assign is_nul  = (ch == stoub_pkg::CH_NUL);
  assign is_x    = (ch == stoub_pkg::CH_LX) || (ch == stoub_pkg::CH_UX);
  assign is_oct  = (ch >= stoub_pkg::CH_ZERO) && (ch <= stoub_pkg::CH_SEVEN);
  assign cfg_bad = (cfg_base == 6'd1) || (cfg_base > stoub_pkg::TOP_BASE);
  assign dig     = stoub_pkg::digit_of(ch);

  // working base seen by the sign/first-digit path
  assign sig_base = (phase_r == PH_WS) ? cfg_base : wbase_r;

  // base used by the digit path, decided straight from the phase
  always_comb begin
    unique case (phase_r)
      PH_WS, PH_SIGNED: dbase_raw = (sig_base == '0) ? 6'd10 : sig_base;
      PH_ZERO:          dbase_raw = (wbase_r == '0) ? (is_oct ? 6'd8 : 6'd10) : wbase_r;
      PH_ZEROX:         dbase_raw = 6'd16;
      default:          dbase_raw = wbase_r;
    endcase
  end

  assign dbase = (dbase_raw < 6'd2) ? 6'd2 : dbase_raw;
  assign prod  = acc_r * dbase;
  assign sum   = {1'b0, prod} + (PROD_W + 1)'(dig);
  assign ovf_hit = |sum[PROD_W:stoub_pkg::VAL_W];

  always_comb begin
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    minus_nxt    = minus_r;
    wbase_nxt    = wbase_r;
    sign_pos_nxt = sign_pos_r;
    stop_pos_nxt = stop_pos_r;
    ovf_nxt      = ovf_r;
    digits_nxt   = digits_r;
    bad_nxt      = bad_r;
    emit         = 1'b0;
    do_signed    = 1'b0;
    do_digit     = 1'b0;
    char_pos_nxt = (char_pos_r >= stoub_pkg::MAX_OFFSET) ? stoub_pkg::MAX_OFFSET
                                                         : char_pos_r + 1'b1;

    unique case (phase_r)
      PH_WS: begin
        if (!stoub_pkg::is_blank(ch)) begin
          sign_pos_nxt = char_pos_r;
          if (cfg_bad) begin
            bad_nxt = 1'b1;
            if (is_nul) begin
              emit = 1'b1;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end else begin
            wbase_nxt = cfg_base;
            if (ch == stoub_pkg::CH_PLUS || ch == stoub_pkg::CH_MINUS) begin
              minus_nxt = (ch == stoub_pkg::CH_MINUS);
              phase_nxt = PH_SIGNED;
            end else begin
              do_signed = 1'b1;
            end
          end
        end
      end
      PH_SIGNED: do_signed = 1'b1;
      PH_ZERO: begin
        if (is_x) begin
          stop_pos_nxt = char_pos_r;
          phase_nxt    = PH_ZEROX;
        end else begin
          wbase_nxt  = dbase_raw;
          acc_nxt    = '0;
          digits_nxt = 1'b1;
          do_digit   = 1'b1;
        end
      end
      PH_ZEROX: begin
        if (dig < 6'd16) begin
          wbase_nxt = 6'd16;
          do_digit  = 1'b1;
        end else begin
          // lone 0x: only the zero counts
          acc_nxt    = '0;
          digits_nxt = 1'b1;
          if (is_nul) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default: begin
        if (is_nul) begin
          emit = 1'b1;
        end
      end
    endcase

    if (do_signed) begin
      if (is_nul) begin
        emit = 1'b1;
      end else if (ch == stoub_pkg::CH_ZERO && (sig_base == '0 || sig_base == 6'd16)) begin
        phase_nxt = PH_ZERO;
      end else begin
        wbase_nxt = dbase_raw;
        do_digit  = 1'b1;
      end
    end

    if (do_digit) begin
      phase_nxt = PH_DIGITS;
      if (is_nul) begin
        stop_pos_nxt = char_pos_r;
        emit         = 1'b1;
      end else if (dig >= dbase) begin
        stop_pos_nxt = char_pos_r;
        phase_nxt    = PH_WAIT;
      end else if (ovf_hit) begin
        stop_pos_nxt = char_pos_r;
        ovf_nxt      = 1'b1;
        phase_nxt    = PH_WAIT;
      end else begin
        acc_nxt    = sum[stoub_pkg::VAL_W-1:0];
        digits_nxt = 1'b1;
      end
    end

    // the accumulator is still zero on every emit path that forces it to zero
    if (bad_nxt) begin
      res.value      = '0;
      res.end_offset = '0;
      res.converted  = 1'b0;
      res.status     = stoub_pkg::ST_BAD_BASE;
    end else if (ovf_nxt) begin
      res.value      = '1;
      res.end_offset = stop_pos_nxt;
      res.converted  = 1'b1;
      res.status     = stoub_pkg::ST_OVF;
    end else begin
      res.value      = minus_r ? (~acc_r + 1'b1) : acc_r;
      res.end_offset = digits_nxt ? stop_pos_nxt : sign_pos_nxt;
      res.converted  = digits_nxt;
      res.status     = stoub_pkg::ST_OK;
    end

    if (emit) begin
      phase_nxt    = PH_WS;
      acc_nxt      = '0;
      minus_nxt    = 1'b0;
      wbase_nxt    = '0;
      char_pos_nxt = '0;
      sign_pos_nxt = '0;
      stop_pos_nxt = '0;
      ovf_nxt      = 1'b0;
      digits_nxt   = 1'b0;
      bad_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WS;
      acc_r      <= '0;
      minus_r    <= 1'b0;
      wbase_r    <= '0;
      char_pos_r <= '0;
      sign_pos_r <= '0;
      stop_pos_r <= '0;
      ovf_r      <= 1'b0;
      digits_r   <= 1'b0;
      bad_r      <= 1'b0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      minus_r    <= minus_nxt;
      wbase_r    <= wbase_nxt;
      char_pos_r <= char_pos_nxt;
      sign_pos_r <= sign_pos_nxt;
      stop_pos_r <= stop_pos_nxt;
      ovf_r      <= ovf_nxt;
      digits_r   <= digits_nxt;
      bad_r      <= bad_nxt;
    end
  end

endmodule

// ----- sv/string_to_unsigned_any_base_unit.sv -----
// string_to_unsigned_any_base_unit: top level with the input register, the
// result register and the base register around stoub_core.
// Depends on stoub_pkg, stoub_in_if, stoub_out_if, stoub_core.
//
// Usage:
//   in_chan carries one character per transfer; a zero byte ends a string and
//   produces exactly one result on out_chan (value, end_offset, converted,
//   status). Characters other than the terminator produce nothing.
//   cfg_we/cfg_wdata write the 6-bit number base; write it only while the
//   block is idle. The base is sampled by the first non-whitespace character
//   (or the terminator) of each string.
//   Throughput: one character per cycle unless out_chan stalls, set by the
//   combinational 64x6 multiply-accumulate with overflow check in stoub_core.
//   Path: a terminator is taken into the input register, stepped through
//   stoub_core and its result is then held in the result register.
//   Stall: while a result waits on out_chan, one more character is taken into
//   the input register; in_chan.ready then drops until the result transfers.
//   Reset (rst_n low, synchronous): both registers empty, parse state back to
//   whitespace skipping, number base 0 (detect from prefix).
module string_to_unsigned_any_base_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  stoub_in_if.sink                      in_chan,
  stoub_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [stoub_pkg::BASE_W-1:0]  cfg_wdata
);

  logic [stoub_pkg::BASE_W-1:0] base_r;
  logic                         in_valid_r, in_valid_nxt;
  logic [stoub_pkg::CH_W-1:0]   in_ch_r;
  logic                         out_valid_r, out_valid_nxt;
  stoub_pkg::stoub_res_t        out_res_r;
  stoub_pkg::stoub_res_t        step_res;
  logic                         step_emit;
  logic                         in_xfer;
  logic                         out_free;
  logic                         advance;

  assign out_free       = !out_valid_r || out_chan.ready;
  assign advance        = in_valid_r && out_free;
  assign in_chan.ready  = !in_valid_r || advance;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  stoub_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (advance),
    .ch       (in_ch_r),
    .cfg_base (base_r),
    .emit     (step_emit),
    .res      (step_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_ch_r <= in_chan.ch;
    end
    if (advance && step_emit) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.value      = out_res_r.value;
  assign out_chan.end_offset = out_res_r.end_offset;
  assign out_chan.converted  = out_res_r.converted;
  assign out_chan.status     = out_res_r.status;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result register not empty after reset");

  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == stoub_pkg::ST_OVF
      |-> out_res_r.value == '1 && out_res_r.converted)
    else $error("overflow result without all-ones value");

  a_bad_base_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == stoub_pkg::ST_BAD_BASE
      |-> out_res_r.value == '0 && out_res_r.end_offset == '0 && !out_res_r.converted)
    else $error("bad base result not cleared");

  a_empty_conv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status == stoub_pkg::ST_OK && !out_res_r.converted
      |-> out_res_r.value == '0)
    else $error("nonzero value with no digit converted");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |-> out_valid_r && !out_chan.ready)
    else $error("input stage stalled with room in result register");

endmodule
